/* hdl/tmpr_pkg.sv */
// Shared types and constants for the tile-map pixel renderer.
`timescale 1ns / 1ps

package tmpr_pkg;

	localparam int DEF_MAP_COLUMNS = 40;
	localparam int DEF_MAP_ROWS    = 30;
	localparam int DEF_TILE_COUNT  = 1200;

	// Result queue behind the pipeline
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	typedef enum logic [1:0] {
		OP_NAME    = 2'd0,
		OP_PATTERN = 2'd1,
		OP_PALETTE = 2'd2,
		OP_RENDER  = 2'd3
	} op_t;

	typedef struct packed {
		logic red;
		logic green;
		logic blue;
	} rgb_t;

endpackage

/* hdl/tmpr_ram.sv */
// Single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module tmpr_ram #(
	parameter int DEPTH = 1200,
	parameter int WIDTH = 12,
	parameter int AW    = 11
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/tmpr_out_fifo.sv */
// Small result queue that decouples the render pipeline from the output channel.
`timescale 1ns / 1ps

module tmpr_out_fifo import tmpr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rgb_t               push_rgb,
	input  logic               pop,
	output rgb_t               head_rgb,
	output logic [FIFO_CW-1:0] count
);

	rgb_t               mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_rgb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + FIFO_CW'(1);
				2'b01:   count_q <= count_q - FIFO_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head_rgb = mem[rd_ptr_q];
	assign count    = count_q;

endmodule

/* hdl/tile_map_pixel_renderer_core.sv */
// Tile-map pixel renderer: name RAM, pattern RAM and palette in a three-stage pipeline.
// Each render reads the name RAM, then the pattern RAM, then the palette; its colour is queued.
// Throughput: one request per cycle while in_ready is high; each RAM port serves one
// request per cycle, and writes go to each store at the stage that reads it, so later renders
// see them in order. Reset clears the pipeline valids, the result queue and view_mode;
// store contents are left as they are and must be loaded before they are read.
`timescale 1ns / 1ps

module tile_map_pixel_renderer_core import tmpr_pkg::*; #(
	parameter int MAP_COLUMNS = DEF_MAP_COLUMNS,
	parameter int MAP_ROWS    = DEF_MAP_ROWS,
	parameter int TILE_COUNT  = DEF_TILE_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [13:0] address,
	input  logic [15:0] write_data,
	input  logic [8:0]  pixel_x,
	input  logic [7:0]  pixel_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        red,
	output logic        green,
	output logic        blue
);

	localparam int NAME_DEPTH = MAP_COLUMNS * MAP_ROWS;
	localparam int NAME_AW    = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;
	localparam int PAT_DEPTH  = TILE_COUNT * 8;
	localparam int PAT_AW     = $clog2(PAT_DEPTH);

	localparam logic [8:0]  COLS_V     = 9'(MAP_COLUMNS);
	localparam logic [8:0]  ROWS_V     = 9'(MAP_ROWS);
	localparam logic [15:0] COLS16     = 16'(MAP_COLUMNS);
	localparam logic [15:0] LAST_TILE  = 16'(TILE_COUNT - 1);
	localparam logic [16:0] NAME_LIMIT = 17'(NAME_DEPTH);
	localparam logic [16:0] PAT_LIMIT  = 17'(PAT_DEPTH);

	// configuration
	logic view_mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			view_mode_q <= cfg_data;
		end
	end

	// stage 0: cell address, name RAM access
	logic               accept;
	op_t                op_in;
	logic [5:0]         cx;
	logic [4:0]         cy;
	logic               oob;
	logic [15:0]        cell_full;
	logic [15:0]        addr16;
	logic               name_we;
	logic [NAME_AW-1:0] name_addr;
	logic [11:0]        name_rdata;

	assign accept    = in_valid && in_ready;
	assign op_in     = op_t'(operation);
	assign cx        = pixel_x[8:3];
	assign cy        = pixel_y[7:3];
	assign oob       = ({3'b0, cx} >= COLS_V) || ({4'b0, cy} >= ROWS_V);
	assign cell_full = 16'(cy) * COLS16 + 16'(cx);
	assign addr16    = {2'b0, address};
	assign name_we   = accept && (op_in == OP_NAME) && ({3'b0, address} < NAME_LIMIT);

	always_comb begin
		if (name_we) begin
			name_addr = addr16[NAME_AW-1:0];
		end else if (oob) begin
			name_addr = '0;
		end else begin
			name_addr = cell_full[NAME_AW-1:0];
		end
	end

	tmpr_ram #(
		.DEPTH (NAME_DEPTH),
		.WIDTH (12),
		.AW    (NAME_AW)
	) u_name_ram (
		.clk   (clk),
		.we    (name_we),
		.addr  (name_addr),
		.wdata (write_data[11:0]),
		.rdata (name_rdata)
	);

	logic               valid_s1;
	op_t                op_s1;
	logic [13:0]        addr_s1;
	logic [15:0]        data_s1;
	logic [2:0]         fx_s1;
	logic [2:0]         fy_s1;
	logic [NAME_AW-1:0] cell_s1;
	logic               oob_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= op_in;
		addr_s1 <= address;
		data_s1 <= write_data;
		fx_s1   <= pixel_x[2:0];
		fy_s1   <= pixel_y[2:0];
		cell_s1 <= oob ? '0 : cell_full[NAME_AW-1:0];
		oob_s1  <= oob;
	end

	// stage 1: tile resolve and clamp, pattern RAM access
	logic [15:0]       tile_raw;
	logic [10:0]       tile;
	logic              base;
	logic              pat_we;
	logic [15:0]       pat_addr16;
	logic [15:0]       pat_rdata;
	logic              render_s1;

	assign tile_raw   = view_mode_q ? 16'(cell_s1) : 16'(name_rdata[10:0]);
	assign tile       = (tile_raw > LAST_TILE) ? LAST_TILE[10:0] : tile_raw[10:0];
	assign base       = view_mode_q ? 1'b0 : name_rdata[11];
	assign pat_we     = valid_s1 && (op_s1 == OP_PATTERN) && ({3'b0, addr_s1} < PAT_LIMIT);
	assign pat_addr16 = pat_we ? {2'b0, addr_s1} : {2'b0, tile, fy_s1};
	assign render_s1  = valid_s1 && (op_s1 == OP_RENDER);

	tmpr_ram #(
		.DEPTH (PAT_DEPTH),
		.WIDTH (16),
		.AW    (PAT_AW)
	) u_pattern_ram (
		.clk   (clk),
		.we    (pat_we),
		.addr  (pat_addr16[PAT_AW-1:0]),
		.wdata (data_s1),
		.rdata (pat_rdata)
	);

	logic       render_s2;
	logic       pal_we_s2;
	logic [2:0] pal_addr_s2;
	logic [2:0] pal_data_s2;
	logic [2:0] fx_s2;
	logic       base_s2;
	logic       oob_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			render_s2 <= 1'b0;
			pal_we_s2 <= 1'b0;
		end else begin
			render_s2 <= render_s1;
			pal_we_s2 <= valid_s1 && (op_s1 == OP_PALETTE) && (addr_s1[13:3] == 11'd0);
		end
	end

	always_ff @(posedge clk) begin
		pal_addr_s2 <= addr_s1[2:0];
		pal_data_s2 <= data_s1[2:0];
		fx_s2       <= fx_s1;
		base_s2     <= base;
		oob_s2      <= oob_s1;
	end

	// stage 2: pixel select and palette lookup
	logic [2:0] palette_q [8];
	logic [1:0] pix;
	logic [2:0] color;
	rgb_t       push_rgb;

	always_ff @(posedge clk) begin
		if (pal_we_s2) begin
			palette_q[pal_addr_s2] <= pal_data_s2;
		end
	end

	assign pix      = pat_rdata[{fx_s2, 1'b0} +: 2];
	assign color    = oob_s2 ? 3'b000 : palette_q[{base_s2, pix}];
	assign push_rgb = '{red: color[2], green: color[1], blue: color[0]};

	// result queue; hold off new requests once every queue slot is spoken for
	logic [FIFO_CW-1:0] fifo_count;
	logic [FIFO_CW:0]   pending;
	rgb_t               head_rgb;
	logic               pop;

	assign pending   = (FIFO_CW + 1)'(fifo_count) + (FIFO_CW + 1)'(render_s1)
	                 + (FIFO_CW + 1)'(render_s2);
	assign in_ready  = pending < (FIFO_CW + 1)'(FIFO_DEPTH);
	assign out_valid = fifo_count != '0;
	assign pop       = out_valid && out_ready;

	tmpr_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (render_s2),
		.push_rgb (push_rgb),
		.pop      (pop),
		.head_rgb (head_rgb),
		.count    (fifo_count)
	);

	assign red   = head_rgb.red;
	assign green = head_rgb.green;
	assign blue  = head_rgb.blue;

endmodule

/* sim/tb.sv */
// Self-checking testbench for the tile-map pixel renderer core.
`timescale 1ns / 1ps

module tb import tmpr_pkg::*; ();

	localparam int MAP_COLUMNS   = DEF_MAP_COLUMNS;
	localparam int MAP_ROWS      = DEF_MAP_ROWS;
	localparam int TILE_COUNT    = DEF_TILE_COUNT;
	localparam int NAME_DEPTH    = MAP_COLUMNS * MAP_ROWS;
	localparam int PATTERN_DEPTH = TILE_COUNT * 8;
	localparam int PALETTE_DEPTH = 8;
	localparam int SETTLE_CYCLES = 6;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		rgb_t       color;
		logic [8:0] x;
		logic [7:0] y;
	} pixel_expect_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	logic        cfg_data   = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_ready;
	logic [1:0]  operation  = OP_NAME;
	logic [13:0] address    = '0;
	logic [15:0] write_data = '0;
	logic [8:0]  pixel_x    = '0;
	logic [7:0]  pixel_y    = '0;
	logic        out_valid;
	logic        out_ready  = 1'b0;
	logic        red;
	logic        green;
	logic        blue;

	// Shadow copy of the block's stores and mode
	logic [11:0] name_mem [0:NAME_DEPTH-1];
	logic [15:0] pattern_mem [0:PATTERN_DEPTH-1];
	rgb_t        palette_mem [0:PALETTE_DEPTH-1];
	bit          name_written [0:NAME_DEPTH-1];
	bit          pattern_written [0:PATTERN_DEPTH-1];
	logic        view_mode_q = 1'b0;

	pixel_expect_t expected_pixels [$];
	int unsigned   mismatch_count = 0;
	int unsigned   items_sent = 0;
	int unsigned   burst_left = 0;
	bit            gaps_on = 1'b1;

	// Receiver stall control
	int unsigned rx_cycle = 0;
	int unsigned rx_hold_id = 0;
	int unsigned rx_hold_ack = 0;
	int unsigned rx_hold_len = 0;
	int unsigned rx_hold_left = 0;

	tile_map_pixel_renderer_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.address    (address),
		.write_data (write_data),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	always #10 clk = ~clk;

	initial begin
		#10_000_000;
		$display("tb failed");
		$finish;
	end

	function automatic int unsigned tile_for_cell(int unsigned cell_idx);
		int unsigned tile;
		if (view_mode_q)
			tile = cell_idx;
		else
			tile = name_mem[cell_idx][10:0];
		if (tile > TILE_COUNT - 1)
			tile = TILE_COUNT - 1;
		return tile;
	endfunction

	function automatic rgb_t predict_pixel(logic [8:0] x, logic [7:0] y);
		int unsigned cell_idx, tile, base, idx;
		logic [15:0] word;
		if (x[8:3] >= MAP_COLUMNS || y[7:3] >= MAP_ROWS)
			return '0;
		cell_idx = y[7:3] * MAP_COLUMNS + x[8:3];
		tile = tile_for_cell(cell_idx);
		base = (!view_mode_q && name_mem[cell_idx][11]) ? 4 : 0;
		word = pattern_mem[tile * 8 + y[2:0]];
		idx = (word >> (2 * x[2:0])) & 16'h3;
		return palette_mem[(base + idx) % PALETTE_DEPTH];
	endfunction

	// Drive one request, hold it until taken, then update the shadow stores
	task automatic send_item(op_t op, logic [13:0] a, logic [15:0] d, logic [8:0] x,
			logic [7:0] y);
		pixel_expect_t want;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid   <= 1'b1;
		operation  <= op;
		address    <= a;
		write_data <= d;
		pixel_x    <= x;
		pixel_y    <= y;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		case (op)
			OP_NAME: if (a < NAME_DEPTH) begin
				name_mem[a] = d[11:0];
				name_written[a] = 1'b1;
			end
			OP_PATTERN: if (a < PATTERN_DEPTH) begin
				pattern_mem[a] = d;
				pattern_written[a] = 1'b1;
			end
			OP_PALETTE: if (a < PALETTE_DEPTH)
				palette_mem[a] = d[2:0];
			default: begin
				want.color = predict_pixel(x, y);
				want.x = x;
				want.y = y;
				expected_pixels.push_back(want);
			end
		endcase
	endtask

	task automatic send_write(op_t op, logic [13:0] a, logic [15:0] d);
		send_item(op, a, d, 9'($urandom), 8'($urandom));
	endtask

	task automatic send_render(logic [8:0] x, logic [7:0] y);
		send_item(OP_RENDER, 14'($urandom), 16'($urandom), x, y);
	endtask

	// Load the pixel's unwritten name and pattern entries, sometimes refresh them anyway
	task automatic prepare_pixel(logic [8:0] x, logic [7:0] y);
		int unsigned cell_idx, addr;
		logic [10:0] tile_id;
		cell_idx = y[7:3] * MAP_COLUMNS + x[8:3];
		if (!view_mode_q && (!name_written[cell_idx] || $urandom_range(0, 4) == 0)) begin
			if ($urandom_range(0, 99) < 85)
				tile_id = 11'($urandom_range(0, TILE_COUNT - 1));
			else
				tile_id = 11'($urandom_range(TILE_COUNT, 2047));
			send_write(OP_NAME, 14'(cell_idx), {4'($urandom), 1'($urandom), tile_id});
		end
		addr = tile_for_cell(cell_idx) * 8 + y[2:0];
		if (!pattern_written[addr] || $urandom_range(0, 5) == 0)
			send_write(OP_PATTERN, 14'(addr), 16'($urandom));
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic change_view_mode(logic mode);
		wait_results_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		view_mode_q = mode;
	endtask

	task automatic random_stream(int unsigned count);
		int unsigned stop_at, pick;
		logic [8:0] x;
		logic [7:0] y;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_write(op_t'($urandom_range(OP_NAME, OP_PALETTE)), 14'($urandom),
						16'($urandom));
			end else if (pick < 13) begin
				send_write(OP_PALETTE, 14'($urandom_range(0, PALETTE_DEPTH - 1)),
						16'($urandom));
			end else if (pick < 23) begin
				if ($urandom_range(0, 1)) begin
					x = 9'($urandom_range(MAP_COLUMNS * 8, 511));
					y = 8'($urandom);
				end else begin
					x = 9'($urandom);
					y = 8'($urandom_range(MAP_ROWS * 8, 255));
				end
				send_render(x, y);
			end else begin
				if ($urandom_range(0, 99) < 40) begin
					x = 9'($urandom_range(0, 31));
					y = 8'($urandom_range(0, 15));
				end else begin
					x = 9'($urandom_range(0, MAP_COLUMNS * 8 - 1));
					y = 8'($urandom_range(0, MAP_ROWS * 8 - 1));
				end
				prepare_pixel(x, y);
				send_render(x, y);
			end
		end
	endtask

	task automatic test_palette_load();
		for (int i = 0; i < PALETTE_DEPTH; i++)
			send_write(OP_PALETTE, 14'(i), {13'($urandom), 3'(i) ^ 3'b101});
		// out of range, must be dropped
		send_write(OP_PALETTE, 14'h3FFF, 16'hFFFF);
	endtask

	task automatic test_name_table_corners();
		send_write(OP_NAME, 14'd0, 16'hF000);
		send_write(OP_PATTERN, 14'd0, 16'hE4E4);
		for (int i = 0; i < 4; i++)
			send_render(9'(i), 8'd0);
		// tile id above the last tile, upper palette half
		send_write(OP_NAME, 14'(NAME_DEPTH - 1), 16'h0FFF);
		send_write(OP_PATTERN, 14'(PATTERN_DEPTH - 1), 16'h1B1B);
		send_render(9'(MAP_COLUMNS * 8 - 1), 8'(MAP_ROWS * 8 - 1));
		send_render(9'(MAP_COLUMNS * 8 - 4), 8'(MAP_ROWS * 8 - 1));
		send_write(OP_NAME, 14'(NAME_DEPTH), 16'hFFFF);
		send_write(OP_PATTERN, 14'(PATTERN_DEPTH), 16'hFFFF);
		send_write(OP_PALETTE, 14'(PALETTE_DEPTH), 16'hFFFF);
		send_render(9'(MAP_COLUMNS * 8 - 1), 8'(MAP_ROWS * 8 - 1));
		// pixels off the map come out black
		send_render(9'(MAP_COLUMNS * 8), 8'd0);
		send_render(9'd0, 8'(MAP_ROWS * 8));
		send_render(9'h1FF, 8'hFF);
	endtask

	task automatic test_direct_corners();
		change_view_mode(1'b1);
		send_render(9'd0, 8'd0);
		send_render(9'd3, 8'd0);
		send_render(9'(MAP_COLUMNS * 8 - 1), 8'(MAP_ROWS * 8 - 1));
		send_render(9'(MAP_COLUMNS * 8), 8'(MAP_ROWS * 8 - 1));
	endtask

	task automatic test_random_direct_mode();
		random_stream(350);
	endtask

	task automatic test_random_name_mode();
		change_view_mode(1'b0);
		random_stream(700);
	endtask

	task automatic test_output_backpressure();
		logic [8:0] x;
		logic [7:0] y;
		wait_results_drained();
		gaps_on = 1'b0;
		rx_hold_len <= 300;
		rx_hold_id  <= rx_hold_id + 1;
		for (int i = 0; i < 40; i++) begin
			x = 9'($urandom_range(0, 31));
			y = 8'($urandom_range(0, 15));
			prepare_pixel(x, y);
			send_render(x, y);
		end
		gaps_on = 1'b1;
		wait_results_drained();
	endtask

	task automatic test_random_back_to_back();
		gaps_on = 1'b0;
		change_view_mode(1'b1);
		random_stream(250);
		change_view_mode(1'b0);
		random_stream(250);
		gaps_on = 1'b1;
	endtask

	// Receiver: rotating stall patterns, plus long holds on request
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_hold_ack != rx_hold_id) begin
			rx_hold_ack  <= rx_hold_id;
			rx_hold_left <= rx_hold_len;
			out_ready    <= 1'b0;
		end else if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
			out_ready    <= 1'b0;
		end else begin
			case (rx_cycle[8:7])
				2'd0: out_ready <= 1'b1;
				2'd1: out_ready <= 1'($urandom_range(0, 1));
				2'd2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= rx_cycle[2];
			endcase
		end
	end

	always @(posedge clk) begin
		pixel_expect_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				if (mismatch_count < REPORT_LIMIT)
					$display("unexpected pixel result r%0b g%0b b%0b", red, green, blue);
				mismatch_count++;
			end else begin
				want = expected_pixels.pop_front();
				if (red !== want.color.red || green !== want.color.green
						|| blue !== want.color.blue) begin
					if (mismatch_count < REPORT_LIMIT)
						$display("pixel (%0d,%0d): expected r%0b g%0b b%0b, got r%0b g%0b b%0b",
								want.x, want.y, want.color.red, want.color.green,
								want.color.blue, red, green, blue);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		change_view_mode(1'b0);
		test_palette_load();
		test_name_table_corners();
		test_direct_corners();
		test_random_direct_mode();
		test_random_name_mode();
		test_output_backpressure();
		test_random_back_to_back();
		wait_results_drained();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
